/* rtl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the bit array with set, clear, test and
// find-first-set / find-first-zero.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int OP_W   = 3;
    localparam int BASE_W = 14;

    localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 3'd0,
        OP_CLEAR      = 3'd1,
        OP_TEST       = 3'd2,
        OP_FIND_SET   = 3'd3,
        OP_FIND_ZERO  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_BIT  = 2'd1,
        ST_SCAN = 2'd2
    } t_state;

endpackage

/* rtl/bsc_ram.sv */
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bsc_word_unit.sv */
// ----------------------------------------------------------------------------
// bsc_word_unit
// Shared word unit: bit update and test for single-bit ops, masked lowest
// match search for one word of a find scan.
// ----------------------------------------------------------------------------
module bsc_word_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]             i_word,
    input  logic [bsc_pkg::BASE_W-1:0]       i_base,
    input  logic [bsc_pkg::CNT_W-1:0]        i_count,
    input  logic                             i_match_one,
    input  logic [$clog2(WORD_BITS)-1:0]     i_bit_off,
    input  logic                             i_bit_set,
    output logic                             o_hit,
    output logic [$clog2(WORD_BITS)-1:0]     o_hit_pos,
    output logic                             o_last,
    output logic [WORD_BITS-1:0]             o_new_word,
    output logic                             o_bit
);

    localparam int BW = $clog2(WORD_BITS);

    logic [bsc_pkg::BASE_W-1:0] rem;
    logic [WORD_BITS-1:0]       mask;
    logic [WORD_BITS-1:0]       cand;

    assign rem    = {1'b0, i_count} - i_base;
    assign o_last = (rem <= bsc_pkg::BASE_W'(WORD_BITS));

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = (bsc_pkg::BASE_W'(j) < rem);
        end
    end

    assign cand  = (i_match_one ? i_word : ~i_word) & mask;
    assign o_hit = |cand;

    // lowest set bit of the candidates
    always_comb begin
        o_hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                o_hit_pos = BW'(j);
            end
        end
    end

    always_comb begin
        o_new_word            = i_word;
        o_new_word[i_bit_off] = i_bit_set;
    end

    assign o_bit = i_word[i_bit_off];

endmodule

/* rtl/bitmap_set_clear_find_first.sv */
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_first
// Bit array with set, clear, test, find first set and find first zero.
// Sequence: in-range set, clear and test pass through ST_BIT before o_done;
// out-of-range and unknown ops strobe o_done straight from ST_IDLE; a find
// scans one word per ST_SCAN step up to a hit or the last in-use word.
// Throughput: one op at a time; the next start is taken in the o_done cycle.
// Synchronous reset clears per-row valid flags (store reads as all zeros)
// and sets the in-use count to 4096; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find_first #(
    parameter int MAX_BITS  = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bsc_pkg::OP_W-1:0]      i_opcode,
    input  logic [bsc_pkg::IDX_W-1:0]     i_bit_addr,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsc_pkg::CNT_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output logic                          o_ok,
    output logic                          o_bit_value,
    output logic [bsc_pkg::IDX_W-1:0]     o_found_index
);

    localparam int DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int BW    = $clog2(WORD_BITS);

    bsc_pkg::t_state                r_state, n_state;
    logic [bsc_pkg::OP_W-1:0]       r_op, n_op;
    logic [AW-1:0]                  r_word, n_word;
    logic [BW-1:0]                  r_off, n_off;
    logic [bsc_pkg::BASE_W-1:0]     r_base, n_base;
    logic [bsc_pkg::CNT_W-1:0]      r_count, n_count;
    logic [bsc_pkg::CNT_W-1:0]      r_cfg_count;
    logic                           r_rd_vld;
    logic [DEPTH-1:0]               r_row_vld;
    logic                           r_done, n_done;
    logic                           r_ok, n_ok;
    logic                           r_bit_value, n_bit_value;
    logic [bsc_pkg::IDX_W-1:0]      r_found_index, n_found_index;

    logic                           accept;
    logic [bsc_pkg::CNT_W-1:0]      live;
    logic                           in_range;
    logic                           is_find;
    logic                           is_bit_op;
    logic [31:0]                    idx_word_full;
    logic [31:0]                    idx_off_full;
    logic [AW-1:0]                  rd_addr;
    logic                           we;
    logic [WORD_BITS-1:0]           ram_q;
    logic [WORD_BITS-1:0]           eff_word;
    logic                           u_hit;
    logic [BW-1:0]                  u_hit_pos;
    logic                           u_last;
    logic [WORD_BITS-1:0]           u_new_word;
    logic                           u_bit;
    logic [bsc_pkg::BASE_W-1:0]     hit_index;

    assign busy        = (r_state != bsc_pkg::ST_IDLE);
    assign accept      = start & ~busy;
    assign o_cfg_ready = 1'b1;

    assign live = ({19'b0, r_cfg_count} > 32'(MAX_BITS)) ? bsc_pkg::CNT_W'(MAX_BITS)
                                                         : r_cfg_count;
    assign in_range = ({1'b0, i_bit_addr} < live);

    assign is_find   = (i_opcode == bsc_pkg::OP_FIND_SET) ||
                       (i_opcode == bsc_pkg::OP_FIND_ZERO);
    assign is_bit_op = (i_opcode == bsc_pkg::OP_SET) || (i_opcode == bsc_pkg::OP_CLEAR) ||
                       (i_opcode == bsc_pkg::OP_TEST);

    assign idx_word_full = {20'b0, i_bit_addr} / WORD_BITS;
    assign idx_off_full  = {20'b0, i_bit_addr} % WORD_BITS;

    assign eff_word  = r_rd_vld ? ram_q : '0;
    assign hit_index = r_base + bsc_pkg::BASE_W'(u_hit_pos);

    bsc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_word),
        .i_wdata (u_new_word),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    bsc_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_unit (
        .i_word      (eff_word),
        .i_base      (r_base),
        .i_count     (r_count),
        .i_match_one (r_op == bsc_pkg::OP_FIND_SET),
        .i_bit_off   (r_off),
        .i_bit_set   (r_op == bsc_pkg::OP_SET),
        .o_hit       (u_hit),
        .o_hit_pos   (u_hit_pos),
        .o_last      (u_last),
        .o_new_word  (u_new_word),
        .o_bit       (u_bit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_find) begin
                        n_state = bsc_pkg::ST_SCAN;
                    end else if (is_bit_op && in_range) begin
                        n_state = bsc_pkg::ST_BIT;
                    end
                end
            end
            bsc_pkg::ST_BIT: begin
                n_state = bsc_pkg::ST_IDLE;
            end
            bsc_pkg::ST_SCAN: begin
                if (u_hit || u_last) begin
                    n_state = bsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op          = r_op;
        n_word        = r_word;
        n_off         = r_off;
        n_base        = r_base;
        n_count       = r_count;
        n_done        = 1'b0;
        n_ok          = r_ok;
        n_bit_value   = r_bit_value;
        n_found_index = r_found_index;
        rd_addr       = '0;
        we            = 1'b0;
        case (r_state)
            bsc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op    = i_opcode;
                    n_count = live;
                    n_base  = '0;
                    n_off   = idx_off_full[BW-1:0];
                    n_word  = is_find ? '0 : idx_word_full[AW-1:0];
                    rd_addr = n_word;
                    if (!is_find && !(is_bit_op && in_range)) begin
                        n_done        = 1'b1;
                        n_ok          = 1'b0;
                        n_bit_value   = 1'b0;
                        n_found_index = '0;
                    end
                end
            end
            bsc_pkg::ST_BIT: begin
                we            = (r_op == bsc_pkg::OP_SET) || (r_op == bsc_pkg::OP_CLEAR);
                n_done        = 1'b1;
                n_ok          = 1'b1;
                n_bit_value   = (r_op == bsc_pkg::OP_TEST) ? u_bit : 1'b0;
                n_found_index = '0;
            end
            bsc_pkg::ST_SCAN: begin
                if (u_hit) begin
                    n_done        = 1'b1;
                    n_ok          = 1'b1;
                    n_bit_value   = 1'b0;
                    n_found_index = hit_index[bsc_pkg::IDX_W-1:0];
                end else if (u_last) begin
                    n_done        = 1'b1;
                    n_ok          = 1'b0;
                    n_bit_value   = 1'b0;
                    n_found_index = '0;
                end else begin
                    n_word  = r_word + AW'(1);
                    n_base  = r_base + bsc_pkg::BASE_W'(WORD_BITS);
                    rd_addr = n_word;
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsc_pkg::ST_IDLE;
            r_done      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_row_vld   <= '0;
            r_cfg_count <= bsc_pkg::CNT_RESET;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_rd_vld <= r_row_vld[rd_addr];
            if (we) begin
                r_row_vld[r_word] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_cfg_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_word        <= n_word;
        r_off         <= n_off;
        r_base        <= n_base;
        r_count       <= n_count;
        r_ok          <= n_ok;
        r_bit_value   <= n_bit_value;
        r_found_index <= n_found_index;
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_bit_value   = r_bit_value;
    assign o_found_index = r_found_index;

endmodule
